// File: hdl/pfc_pkg.sv
// Shared types, constants and lookup helpers for the Playfair digraph cipher.
`default_nettype none

package pfc_pkg;

	localparam int Side = 5;
	localparam int RowW = 3;

	localparam logic [4:0] CodeX = 5'd23;
	localparam logic [4:0] CodeI = 5'd8;
	localparam logic [4:0] CodeJ = 5'd9;

	localparam logic [7:0] AsciiUpperA = 8'd65;
	localparam logic [7:0] AsciiUpperZ = 8'd90;
	localparam logic [7:0] AsciiLowerA = 8'd97;
	localparam logic [7:0] AsciiLowerZ = 8'd122;
	localparam logic [7:0] CaseOffset  = 8'd32;
	localparam logic [6:0] LetterBase  = 7'd65;

	localparam logic [7:0] RegCellsLow = 8'd0;
	localparam logic [7:0] RegCellsMid = 8'd1;
	localparam logic [7:0] RegCellLast = 8'd2;
	localparam logic [7:0] RegMode     = 8'd3;

	localparam int CfgW = 60;

	// Queue depth is a power of two so that the pointers wrap by themselves.
	localparam int QueueDepth = 4;
	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	typedef logic [Side-1:0][Side-1:0][4:0] square_t;

	typedef struct packed {
		logic            found;
		logic [RowW-1:0] row;
		logic [RowW-1:0] col;
	} loc_t;

	typedef struct packed {
		logic [RowW-1:0] ra;
		logic [RowW-1:0] ca;
		logic [RowW-1:0] rb;
		logic [RowW-1:0] cb;
		logic            enc;
		logic            run_last;
		logic            msg_end;
	} pair_t;

	typedef struct packed {
		logic [1:0] count;
		pair_t      first;
		pair_t      second;
	} push_t;

	// First matching cell in row-major order wins.
	function automatic loc_t find_cell(input square_t sq, input logic [4:0] code);
		loc_t f;
		f = '0;
		for (int r = Side - 1; r >= 0; r--) begin
			for (int c = Side - 1; c >= 0; c--) begin
				if (sq[r][c] == code) begin
					f.found = 1'b1;
					f.row   = RowW'(r);
					f.col   = RowW'(c);
				end
			end
		end
		return f;
	endfunction

	function automatic logic [RowW-1:0] wrap_step(input logic [RowW-1:0] v, input logic fwd);
		logic [RowW-1:0] r;
		if (fwd) begin
			r = (v == RowW'(Side - 1)) ? '0 : v + RowW'(1);
		end else begin
			r = (v == '0) ? RowW'(Side - 1) : v - RowW'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/playfair_digraph_cipher.sv
// Top level of the streaming Playfair cipher: key square registers and the three stages.
//
//  word     | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  message  | in        | in_valid/in_ready  | char_byte, message_last
//  letters  | out       | out_valid/out_ready| out_letter, run_last, message_end
//  config   | in        | cfg_write          | cfg_index, cfg_data
//
// An input word is taken whenever the pair queue has two free slots. The back end
// emits one letter per cycle while out_ready holds, two letters per pair, so the
// output side sets the sustained rate; a letter passes the pair queue and then the
// output register. Reset clears the pending letter, the queue and out_valid, and
// sets encrypt mode. Either side may stall; the queue absorbs up to four pairs.
`default_nettype none

module playfair_digraph_cipher (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire  [7:0]               char_byte,
	input  wire                      message_last,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [6:0]               out_letter,
	output logic                     run_last,
	output logic                     message_end,
	input  wire                      cfg_write,
	input  wire  [7:0]               cfg_index,
	input  wire  [pfc_pkg::CfgW-1:0] cfg_data
);
	import pfc_pkg::*;

	logic [CfgW-1:0] cells_low_q;
	logic [CfgW-1:0] cells_mid_q;
	logic [4:0]      cell_last_q;
	logic            enc_q;

	square_t square;
	push_t   push;
	pair_t   head;
	logic    space_ok;
	logic    head_valid;
	logic    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_low_q <= '0;
			cells_mid_q <= '0;
			cell_last_q <= '0;
			enc_q       <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				RegCellsLow: cells_low_q <= cfg_data;
				RegCellsMid: cells_mid_q <= cfg_data;
				RegCellLast: cell_last_q <= cfg_data[4:0];
				RegMode:     enc_q       <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// Cells are packed row-major: twelve in each wide register, then the last one.
	always_comb begin
		for (int r = 0; r < Side; r++) begin
			for (int c = 0; c < Side; c++) begin
				if (r * Side + c < 12) begin
					square[r][c] = cells_low_q[5*(r*Side+c) +: 5];
				end else if (r * Side + c < 24) begin
					square[r][c] = cells_mid_q[5*(r*Side+c-12) +: 5];
				end else begin
					square[r][c] = cell_last_q;
				end
			end
		end
	end

	pfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_byte    (char_byte),
		.message_last (message_last),
		.square       (square),
		.enc          (enc_q),
		.space_ok     (space_ok),
		.push         (push)
	);

	pfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.space_ok   (space_ok),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	pfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.square      (square),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_letter  (out_letter),
		.run_last    (run_last),
		.message_end (message_end)
	);

endmodule

`default_nettype wire

// File: hdl/pfc_front.sv
// Front end: letter classification, pairing, square lookup and queue writes.
`default_nettype none

module pfc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          char_byte,
	input  wire                 message_last,
	input  pfc_pkg::square_t    square,
	input  wire                 enc,
	input  wire                 space_ok,
	output pfc_pkg::push_t      push
);
	import pfc_pkg::*;

	logic       pend_valid_q;
	logic [4:0] pend_code_q;

	logic [7:0] upper;
	logic       is_letter;
	logic [4:0] code;
	loc_t       loc_c;
	loc_t       loc_x;
	loc_t       loc_p;

	logic       p1_exist;
	loc_t       p1_a;
	loc_t       p1_b;
	logic       nxt_valid;
	logic [4:0] nxt_code;
	loc_t       nxt_loc;
	logic       p2_exist;
	logic       p1_ok;
	logic       p2_ok;
	pair_t      pair1;
	pair_t      pair2;
	logic       accept;

	assign in_ready = space_ok;
	assign accept   = in_valid && space_ok;

	always_comb begin
		upper = char_byte;
		if (char_byte >= AsciiLowerA && char_byte <= AsciiLowerZ) begin
			upper = char_byte - CaseOffset;
		end
		is_letter = (upper >= AsciiUpperA) && (upper <= AsciiUpperZ);
		code = 5'(upper - AsciiUpperA);
		if (code == CodeJ) begin
			code = CodeI;
		end
		loc_c = find_cell(square, code);
		loc_x = find_cell(square, CodeX);
		// The waiting letter is looked up in the square that is in force now.
		loc_p = find_cell(square, pend_code_q);
	end

	always_comb begin
		p1_exist  = 1'b0;
		p1_a      = loc_p;
		p1_b      = loc_c;
		nxt_valid = pend_valid_q;
		nxt_code  = pend_code_q;
		nxt_loc   = loc_p;
		if (is_letter) begin
			if (!pend_valid_q) begin
				nxt_valid = 1'b1;
				nxt_code  = code;
				nxt_loc   = loc_c;
			end else if (enc && pend_code_q == code) begin
				// A doubled letter is split with X and the second one waits.
				p1_exist = 1'b1;
				p1_b     = loc_x;
				nxt_code = code;
				nxt_loc  = loc_c;
			end else begin
				p1_exist  = 1'b1;
				nxt_valid = 1'b0;
				nxt_code  = '0;
			end
		end
		p2_exist = message_last && nxt_valid;
		if (message_last) begin
			nxt_valid = 1'b0;
			nxt_code  = '0;
		end

		p1_ok = p1_exist && p1_a.found && p1_b.found;
		p2_ok = p2_exist && nxt_loc.found && loc_x.found;

		pair1.ra       = p1_a.row;
		pair1.ca       = p1_a.col;
		pair1.rb       = p1_b.row;
		pair1.cb       = p1_b.col;
		pair1.enc      = enc;
		pair1.run_last = !p2_ok;
		pair1.msg_end  = message_last && !p2_ok;

		pair2.ra       = nxt_loc.row;
		pair2.ca       = nxt_loc.col;
		pair2.rb       = loc_x.row;
		pair2.cb       = loc_x.col;
		pair2.enc      = enc;
		pair2.run_last = 1'b1;
		pair2.msg_end  = 1'b1;

		push.count  = accept ? (2'(p1_ok) + 2'(p2_ok)) : 2'd0;
		push.first  = p1_ok ? pair1 : pair2;
		push.second = pair2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_code_q  <= '0;
		end else if (accept) begin
			pend_valid_q <= nxt_valid;
			pend_code_q  <= nxt_code;
		end
	end

endmodule

`default_nettype wire

// File: hdl/pfc_queue.sv
// Short pair queue between front and back; takes up to two pairs a cycle.
`default_nettype none

module pfc_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pfc_pkg::push_t      push,
	output logic                space_ok,
	output logic                head_valid,
	output pfc_pkg::pair_t      head,
	input  wire                 pop
);
	import pfc_pkg::*;

	pair_t           entries_q [QueueDepth];
	logic [PtrW-1:0] wp_q;
	logic [PtrW-1:0] rp_q;
	logic [CntW-1:0] count_q;

	assign space_ok   = count_q <= CntW'(QueueDepth - 2);
	assign head_valid = count_q != '0;
	assign head       = entries_q[rp_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entries_q[wp_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entries_q[wp_q + PtrW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PtrW'(push.count);
			rp_q    <= rp_q + PtrW'(pop);
			count_q <= count_q + CntW'(push.count) - CntW'(pop);
		end
	end

endmodule

`default_nettype wire

// File: hdl/pfc_back.sv
// Back end: applies the column, row or rectangle rule and drives the output word.
`default_nettype none

module pfc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pfc_pkg::square_t    square,
	input  wire                 head_valid,
	input  pfc_pkg::pair_t      head,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [6:0]          out_letter,
	output logic                run_last,
	output logic                message_end
);
	import pfc_pkg::*;

	logic            phase_q;
	logic            out_valid_q;
	logic [6:0]      out_letter_q;
	logic            run_last_q;
	logic            message_end_q;

	logic            take;
	logic [RowW-1:0] row;
	logic [RowW-1:0] col;
	logic [4:0]      sq_code;

	assign take = head_valid && (!out_valid_q || out_ready);
	assign pop  = take && phase_q;

	always_comb begin
		if (head.ca == head.cb) begin
			row = wrap_step(phase_q ? head.rb : head.ra, head.enc);
			col = phase_q ? head.cb : head.ca;
		end else if (head.ra == head.rb) begin
			row = phase_q ? head.rb : head.ra;
			col = wrap_step(phase_q ? head.cb : head.ca, head.enc);
		end else begin
			row = phase_q ? head.rb : head.ra;
			col = phase_q ? head.ca : head.cb;
		end
		sq_code = square[row][col];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_letter_q  <= LetterBase + 7'(sq_code);
			run_last_q    <= phase_q && head.run_last;
			message_end_q <= phase_q && head.msg_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= !phase_q;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_letter  = out_letter_q;
	assign run_last    = run_last_q;
	assign message_end = message_end_q;

endmodule

`default_nettype wire
